// File: src/jdh_pkg.sv
package jdh_pkg;

    // Field widths.
    localparam int SAMPLE_W = 12;
    localparam int OFFSET_W = 12;
    localparam int SUM_W    = 18;
    localparam int CNT_W    = 7;
    localparam int DIFF_W   = SAMPLE_W + 2;

    // Number of items averaged to find each axis centre (1 to 64).
    localparam int CAL_SAMPLES = 10;

    // Exact truncating division of an SUM_W-bit sum by CAL_SAMPLES:
    // multiply by ceil(2^CAL_K / CAL_SAMPLES) and keep the bits above CAL_K.
    localparam int CAL_K   = SUM_W + $clog2(CAL_SAMPLES);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] CAL_RECIP =
        RECIP_W'(((64'd1 << CAL_K) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    // Stream payload widths.
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    // Offset register reset values.
    localparam logic [OFFSET_W-1:0] PRESS_RESET   = OFFSET_W'(300);
    localparam logic [OFFSET_W-1:0] RELEASE_RESET = OFFSET_W'(250);

    // Configuration register indices.
    typedef enum logic [0:0] {
        REG_PRESS_OFFSET   = 1'b0,
        REG_RELEASE_OFFSET = 1'b1
    } cfg_reg_t;

    // Direction flag pair of one axis.
    typedef struct packed {
        logic high;
        logic low;
    } axis_flags_t;

    // Calibration status handed from the calibration unit to the datapath.
    typedef struct packed {
        logic                active;
        logic [SAMPLE_W-1:0] x_center;
        logic [SAMPLE_W-1:0] y_center;
    } cal_status_t;

endpackage

// File: src/jdh_axis.sv
module jdh_axis (
    input  logic [jdh_pkg::SAMPLE_W-1:0] sample,
    input  logic [jdh_pkg::SAMPLE_W-1:0] center,
    input  logic [jdh_pkg::OFFSET_W-1:0] press_offset,
    input  logic [jdh_pkg::OFFSET_W-1:0] release_offset,
    input  jdh_pkg::axis_flags_t         flags_in,
    output jdh_pkg::axis_flags_t         flags_out
);

    logic signed [jdh_pkg::DIFF_W-1:0] diff;
    logic signed [jdh_pkg::DIFF_W-1:0] press_pos;
    logic signed [jdh_pkg::DIFF_W-1:0] press_neg;
    logic signed [jdh_pkg::DIFF_W-1:0] release_pos;
    logic signed [jdh_pkg::DIFF_W-1:0] release_neg;

    assign diff        = $signed({2'b00, sample}) - $signed({2'b00, center});
    assign press_pos   = $signed({2'b00, press_offset});
    assign press_neg   = -press_pos;
    assign release_pos = $signed({2'b00, release_offset});
    assign release_neg = -release_pos;

    // Set tests first, then the clear tests, so clearing wins on overlap.
    always_comb begin
        flags_out = flags_in;
        if (diff < press_neg) begin
            flags_out.low = 1'b1;
        end
        if (diff > press_pos) begin
            flags_out.high = 1'b1;
        end
        if (diff > release_neg) begin
            flags_out.low = 1'b0;
        end
        if (diff < release_pos) begin
            flags_out.high = 1'b0;
        end
    end

endmodule

// File: src/jdh_cal.sv
module jdh_cal (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic                         restart,
    input  logic [jdh_pkg::SAMPLE_W-1:0] x_sample,
    input  logic [jdh_pkg::SAMPLE_W-1:0] y_sample,
    output jdh_pkg::cal_status_t         status
);

    logic [jdh_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [jdh_pkg::SUM_W-1:0]    x_sum_reg, x_sum_next;
    logic [jdh_pkg::SUM_W-1:0]    y_sum_reg, y_sum_next;
    logic [jdh_pkg::SAMPLE_W-1:0] x_center_reg, x_center_next;
    logic [jdh_pkg::SAMPLE_W-1:0] y_center_reg, y_center_next;
    logic                         calibrated_reg, calibrated_next;
    logic [jdh_pkg::PROD_W-1:0]   x_prod;
    logic [jdh_pkg::PROD_W-1:0]   y_prod;
    logic                         active;

    // A restart request drops calibration before the item is looked at.
    assign active = calibrated_reg & ~restart;

    always_comb begin
        count_next      = count_reg;
        x_sum_next      = x_sum_reg;
        y_sum_next      = y_sum_reg;
        calibrated_next = calibrated_reg;
        x_center_next   = x_center_reg;
        y_center_next   = y_center_reg;
        x_prod          = '0;
        y_prod          = '0;
        if (restart) begin
            count_next      = '0;
            x_sum_next      = '0;
            y_sum_next      = '0;
            calibrated_next = 1'b0;
        end
        if (!active) begin
            x_sum_next = x_sum_next + jdh_pkg::SUM_W'(x_sample);
            y_sum_next = y_sum_next + jdh_pkg::SUM_W'(y_sample);
            count_next = count_next + 1'b1;
            x_prod = jdh_pkg::PROD_W'(x_sum_next) * jdh_pkg::PROD_W'(jdh_pkg::CAL_RECIP);
            y_prod = jdh_pkg::PROD_W'(y_sum_next) * jdh_pkg::PROD_W'(jdh_pkg::CAL_RECIP);
            if (count_next >= jdh_pkg::CNT_W'(jdh_pkg::CAL_SAMPLES)) begin
                x_center_next   = x_prod[jdh_pkg::CAL_K +: jdh_pkg::SAMPLE_W];
                y_center_next   = y_prod[jdh_pkg::CAL_K +: jdh_pkg::SAMPLE_W];
                calibrated_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            x_sum_reg      <= '0;
            y_sum_reg      <= '0;
            x_center_reg   <= '0;
            y_center_reg   <= '0;
            calibrated_reg <= 1'b0;
        end else if (advance) begin
            count_reg      <= count_next;
            x_sum_reg      <= x_sum_next;
            y_sum_reg      <= y_sum_next;
            x_center_reg   <= x_center_next;
            y_center_reg   <= y_center_next;
            calibrated_reg <= calibrated_next;
        end
    end

    assign status.active   = active;
    assign status.x_center = x_center_reg;
    assign status.y_center = y_center_reg;

endmodule

// File: src/joystick_direction_hysteresis.sv
// A result shows on m_tvalid after its item passes the input register, then the result register.
// Throughput: one item per cycle, sustained while m_tready stays high; the input register and the result
// register let a new item be taken while a finished result waits for m_tready.
// Reset (aresetn low, synchronous) empties both registers, clears the sums,
// the count, the centres and the direction flags, and restores the offsets
// to 300 and 250; the block then calibrates on the next CAL_SAMPLES items.
module joystick_direction_hysteresis (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [11:0] x_sample, [23:12] y_sample, [24] button_a, [25] button_b,
    // [26] button_c, [27] button_d, [28] restart_calibration, [31:29] zero
    input  logic [jdh_pkg::S_DATA_W-1:0]  s_tdata,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] ready_res, [1] left, [2] right, [3] up, [4] down, [5] out_a,
    // [6] out_b, [7] out_c, [8] out_d, [15:9] zero
    output logic [jdh_pkg::M_DATA_W-1:0]  m_tdata,
    // Configuration writes.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  jdh_pkg::cfg_reg_t             cfg_index,
    input  logic [jdh_pkg::OFFSET_W-1:0]  cfg_data
);

    // Input register: holds one accepted item until the result register can
    // take its result.
    logic                         in_valid_reg;
    logic [jdh_pkg::SAMPLE_W-1:0] x_reg;
    logic [jdh_pkg::SAMPLE_W-1:0] y_reg;
    logic [3:0]                   buttons_reg;
    logic                         restart_reg;

    // Result register.
    logic                         out_valid_reg;
    logic [jdh_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;

    // Offsets and the four direction flags.
    logic [jdh_pkg::OFFSET_W-1:0] press_reg;
    logic [jdh_pkg::OFFSET_W-1:0] release_reg;
    jdh_pkg::axis_flags_t         x_flags_reg, x_flags_next, x_flags_upd;
    jdh_pkg::axis_flags_t         y_flags_reg, y_flags_next, y_flags_upd;

    jdh_pkg::cal_status_t         cal_status;
    logic                         out_free;
    logic                         advance;
    logic                         s_accept;

    // The result register frees up when it is empty or its transfer completes;
    // an item moves from the input register into it in that same cycle.
    assign out_free = ~out_valid_reg | m_tready;
    assign advance  = in_valid_reg & out_free;
    assign s_tready = ~in_valid_reg | out_free;
    assign s_accept = s_tvalid & s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg       <= s_tdata[11:0];
            y_reg       <= s_tdata[23:12];
            buttons_reg <= s_tdata[27:24];
            restart_reg <= s_tdata[28];
        end
    end

    // Offset registers; the user must write them only while the block is idle, and the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_reg   <= jdh_pkg::PRESS_RESET;
            release_reg <= jdh_pkg::RELEASE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                jdh_pkg::REG_PRESS_OFFSET:   press_reg   <= cfg_data;
                jdh_pkg::REG_RELEASE_OFFSET: release_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Calibration unit: sums, count, centres and the calibrated bit.
    jdh_cal u_cal (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .restart  (restart_reg),
        .x_sample (x_reg),
        .y_sample (y_reg),
        .status   (cal_status)
    );

    jdh_axis u_axis_x (
        .sample         (x_reg),
        .center         (cal_status.x_center),
        .press_offset   (press_reg),
        .release_offset (release_reg),
        .flags_in       (x_flags_reg),
        .flags_out      (x_flags_upd)
    );

    jdh_axis u_axis_y (
        .sample         (y_reg),
        .center         (cal_status.y_center),
        .press_offset   (press_reg),
        .release_offset (release_reg),
        .flags_in       (y_flags_reg),
        .flags_out      (y_flags_upd)
    );

    // Any item taken for calibration (restart, running or completing) leaves
    // the flags clear and reports them as zero.
    always_comb begin
        if (cal_status.active) begin
            x_flags_next = x_flags_upd;
            y_flags_next = y_flags_upd;
        end else begin
            x_flags_next = '0;
            y_flags_next = '0;
        end
        out_data_next = {7'b0000000, buttons_reg[3], buttons_reg[2],
                         buttons_reg[1], buttons_reg[0],
                         y_flags_next.high, y_flags_next.low,
                         x_flags_next.high, x_flags_next.low,
                         cal_status.active};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_flags_reg <= '0;
            y_flags_reg <= '0;
        end else if (advance) begin
            x_flags_reg <= x_flags_next;
            y_flags_reg <= y_flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A result that is not ready never shows a direction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'b0000)
        else $error("direction reported while calibrating");

    // Hysteresis never leaves both flags of one axis set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(x_flags_reg.low && x_flags_reg.high) && !(y_flags_reg.low && y_flags_reg.high))
        else $error("opposite direction flags set together");

    // A calibration item leaves the flags clear for the next item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !cal_status.active |=> x_flags_reg == '0 && y_flags_reg == '0)
        else $error("flags not cleared by calibration item");

    // An empty result register never holds back the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

// File: tb/sv/joystick_direction_hysteresis_tb.sv
`timescale 1ns / 100ps

module joystick_direction_hysteresis_tb;

    // One input item as it travels on s_tdata, last field in the lowest bits.
    typedef struct packed {
        logic [2:0]                   pad;
        logic                         restart;
        logic                         btn_d;
        logic                         btn_c;
        logic                         btn_b;
        logic                         btn_a;
        logic [jdh_pkg::SAMPLE_W-1:0] y;
        logic [jdh_pkg::SAMPLE_W-1:0] x;
    } joy_item_t;

    // One result item as it travels on m_tdata.
    typedef struct packed {
        logic [6:0] pad;
        logic       out_d;
        logic       out_c;
        logic       out_b;
        logic       out_a;
        logic       down;
        logic       up;
        logic       right;
        logic       left;
        logic       ready_res;
    } joy_result_t;

    localparam int  SAMPLE_MAX  = (1 << jdh_pkg::SAMPLE_W) - 1;
    localparam int  SUM_MASK    = (1 << jdh_pkg::SUM_W) - 1;
    localparam int  CNT_MASK    = (1 << jdh_pkg::CNT_W) - 1;
    localparam int  FIELD_COUNT = 9;
    localparam int  CYCLE_LIMIT = 500000;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    // [11:0] x_sample, [23:12] y_sample, [24] button_a, [25] button_b,
    // [26] button_c, [27] button_d, [28] restart_calibration, [31:29] zero
    logic [jdh_pkg::S_DATA_W-1:0]  s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    // [0] ready_res, [1] left, [2] right, [3] up, [4] down, [5] out_a,
    // [6] out_b, [7] out_c, [8] out_d, [15:9] zero
    logic [jdh_pkg::M_DATA_W-1:0]  m_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    jdh_pkg::cfg_reg_t             cfg_index;
    logic [jdh_pkg::OFFSET_W-1:0]  cfg_data;

    joystick_direction_hysteresis uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Our own copy of the block's state and offset registers. It is advanced
    // once per accepted input transfer and once per configuration write.
    int                   press_ofs;
    int                   release_ofs;
    int                   cal_cnt;
    int                   x_acc;
    int                   y_acc;
    int                   x_ctr;
    int                   y_ctr;
    bit                   is_calibrated;
    jdh_pkg::axis_flags_t x_flags;
    jdh_pkg::axis_flags_t y_flags;

    // Results predicted for accepted items, oldest first.
    joy_result_t joy_results_due[$];

    int          mismatch_count;
    int          cycle_count;
    int          stall_left;
    // When set, neither side inserts any idle cycles.
    bit          steady;

    string field_names [FIELD_COUNT] = '{"ready_res", "left", "right", "up", "down",
                                         "out_a", "out_b", "out_c", "out_d"};

    // Free-running clock with a 10 ns period.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a run that has not finished well within this many cycles is
    // taken to be hung.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Hysteresis update of one axis. The set tests come first and the clear
    // tests second, so that when the release band is wider than the press
    // band the clear always wins.
    function automatic jdh_pkg::axis_flags_t step_axis(jdh_pkg::axis_flags_t flags,
                                                       int sample, int centre);
        int                   delta;
        jdh_pkg::axis_flags_t next;
        delta = sample - centre;
        next = flags;
        if (delta < -press_ofs)
            next.low = 1'b1;
        if (delta > press_ofs)
            next.high = 1'b1;
        if (delta > -release_ofs)
            next.low = 1'b0;
        if (delta < release_ofs)
            next.high = 1'b0;
        return next;
    endfunction

    // Works out the result of one input item and advances the predicted state.
    function automatic joy_result_t predict_joystick(joy_item_t item);
        joy_result_t res;
        res = '0;
        if (item.restart) begin
            x_acc         = 0;
            y_acc         = 0;
            cal_cnt       = 0;
            is_calibrated = 1'b0;
            x_flags       = '0;
            y_flags       = '0;
        end
        if (!is_calibrated) begin
            // Calibrating items, the last one included, report no direction.
            x_acc   = (x_acc + int'(item.x)) & SUM_MASK;
            y_acc   = (y_acc + int'(item.y)) & SUM_MASK;
            cal_cnt = (cal_cnt + 1) & CNT_MASK;
            if (cal_cnt >= jdh_pkg::CAL_SAMPLES) begin
                x_ctr         = (x_acc / jdh_pkg::CAL_SAMPLES) & SAMPLE_MAX;
                y_ctr         = (y_acc / jdh_pkg::CAL_SAMPLES) & SAMPLE_MAX;
                is_calibrated = 1'b1;
                x_flags       = '0;
                y_flags       = '0;
            end
        end else begin
            x_flags       = step_axis(x_flags, int'(item.x), x_ctr);
            y_flags       = step_axis(y_flags, int'(item.y), y_ctr);
            res.ready_res = 1'b1;
            res.left      = x_flags.low;
            res.right     = x_flags.high;
            res.up        = y_flags.low;
            res.down      = y_flags.high;
        end
        res.out_a = item.btn_a;
        res.out_b = item.btn_b;
        res.out_c = item.btn_c;
        res.out_d = item.btn_d;
        return res;
    endfunction

    function automatic joy_item_t make_item(int x, int y, logic [3:0] buttons, logic restart);
        joy_item_t item;
        item         = '0;
        item.x       = jdh_pkg::SAMPLE_W'(x);
        item.y       = jdh_pkg::SAMPLE_W'(y);
        item.btn_a   = buttons[0];
        item.btn_b   = buttons[1];
        item.btn_c   = buttons[2];
        item.btn_d   = buttons[3];
        item.restart = restart;
        return item;
    endfunction

    // A sample within +/- spread of a centre, clipped to the converter range.
    function automatic int near_sample(int centre, int spread);
        int v;
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v;
    endfunction

    // Sends one item and records its expected result once the transfer has
    // taken place. The valid is only lowered when a gap is to follow, so it
    // never falls and rises within the same time step.
    task automatic send_item(joy_item_t item);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do
            @(posedge aclk);
        while (!s_tready);
        joy_results_due.push_back(predict_joystick(item));
    endtask

    // Holds the sender off until every outstanding result has been checked.
    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (joy_results_due.size() != 0)
            @(posedge aclk);
    endtask

    // Writes one offset register. The block is drained first, so the new
    // value cannot take effect in the middle of a stream of items.
    task automatic write_offset(jdh_pkg::cfg_reg_t idx, int value);
        wait_results_drained();
        repeat (2) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= jdh_pkg::OFFSET_W'(value);
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            jdh_pkg::REG_PRESS_OFFSET: begin
                press_ofs = value & SAMPLE_MAX;
            end
            jdh_pkg::REG_RELEASE_OFFSET: begin
                release_ofs = value & SAMPLE_MAX;
            end
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_offsets(int press, int release_val);
        write_offset(jdh_pkg::REG_PRESS_OFFSET, press);
        write_offset(jdh_pkg::REG_RELEASE_OFFSET, release_val);
    endtask

    // Calibration straight after reset, interrupted by a restart part-way
    // through. After the restart the samples alternate between the two ends
    // of the range, so both centres come out at 2047.
    task automatic test_calibration();
        int k;
        for (k = 0; k < 4; k++)
            send_item(make_item(k * 1000, SAMPLE_MAX - k * 1000, 4'(k * 5), 1'b0));
        for (k = 0; k < jdh_pkg::CAL_SAMPLES; k++) begin
            send_item(make_item((k % 2 == 0) ? SAMPLE_MAX : 0,
                                (k % 2 == 0) ? 0 : SAMPLE_MAX,
                                (k % 2 == 0) ? 4'(k) : ~4'(k), k == 0));
        end
    endtask

    // Direction flags at the reset offsets of 300 and 250, stepping across
    // the press and release thresholds one count at a time.
    task automatic test_directions();
        send_item(make_item(0, x_ctr, 4'b0001, 1'b0));
        send_item(make_item(x_ctr, y_ctr, 4'b0010, 1'b0));
        send_item(make_item(x_ctr + 300, y_ctr, 4'b0100, 1'b0));
        send_item(make_item(x_ctr + 301, y_ctr, 4'b1000, 1'b0));
        send_item(make_item(x_ctr + 250, y_ctr, 4'b1111, 1'b0));
        send_item(make_item(x_ctr + 249, y_ctr - 301, 4'b0000, 1'b0));
        send_item(make_item(x_ctr, y_ctr - 249, 4'b1010, 1'b0));
        send_item(make_item(x_ctr, SAMPLE_MAX, 4'b0101, 1'b0));
    endtask

    // Offsets at the edges of their range, and a release band wider than
    // the press band, where a flag set between the two thresholds is cleared again at once.
    task automatic test_offset_extremes();
        set_offsets(SAMPLE_MAX, 0);
        send_item(make_item(0, SAMPLE_MAX, 4'b0011, 1'b0));
        send_item(make_item(SAMPLE_MAX, 0, 4'b1100, 1'b0));
        set_offsets(0, 0);
        send_item(make_item(x_ctr + 1, y_ctr - 1, 4'b0110, 1'b0));
        send_item(make_item(x_ctr, y_ctr, 4'b1001, 1'b0));
        set_offsets(100, 400);
        send_item(make_item(x_ctr + 300, y_ctr - 300, 4'b0111, 1'b0));
        set_offsets(int'(jdh_pkg::PRESS_RESET), int'(jdh_pkg::RELEASE_RESET));
    endtask

    // Phases of random traffic. Each phase picks a pair of offsets, restarts
    // calibration around a chosen centre and then moves both axes about the
    // thresholds, with some full-range samples and the odd stray restart.
    task automatic test_random();
        int        phase;
        int        n;
        int        cx;
        int        cy;
        int        spread;
        int        p;
        joy_item_t item;
        for (phase = 0; phase < 10; phase++) begin
            steady = (phase % 4 == 3);
            case (phase)
                0: set_offsets(300, 250);
                1: set_offsets(0, 0);
                2: set_offsets(SAMPLE_MAX, SAMPLE_MAX);
                3: set_offsets(100, 400);
                4: set_offsets(SAMPLE_MAX, 0);
                5: set_offsets(0, SAMPLE_MAX);
                default: begin
                    p = $urandom_range(0, 1000);
                    set_offsets(p, $urandom_range(0, 99) < 80 ? $urandom_range(0, p)
                                                              : $urandom_range(0, 1000));
                end
            endcase
            cx = ($urandom_range(0, 9) < 2) ? ($urandom_range(0, 1) ? SAMPLE_MAX : 0)
                                            : $urandom_range(0, SAMPLE_MAX);
            cy = ($urandom_range(0, 9) < 2) ? ($urandom_range(0, 1) ? SAMPLE_MAX : 0)
                                            : $urandom_range(0, SAMPLE_MAX);
            for (n = 0; n < jdh_pkg::CAL_SAMPLES; n++) begin
                item         = joy_item_t'($urandom);
                item.pad     = '0;
                item.x       = jdh_pkg::SAMPLE_W'(near_sample(cx, 40));
                item.y       = jdh_pkg::SAMPLE_W'(near_sample(cy, 40));
                item.restart = (n == 0);
                send_item(item);
            end
            spread = ((press_ofs > release_ofs) ? press_ofs : release_ofs) + 64;
            if (spread > SAMPLE_MAX)
                spread = SAMPLE_MAX;
            for (n = 0; n < 60; n++) begin
                item         = joy_item_t'($urandom);
                item.pad     = '0;
                item.restart = ($urandom_range(0, 99) < 2);
                if ($urandom_range(0, 99) < 88) begin
                    item.x = jdh_pkg::SAMPLE_W'(near_sample(x_ctr, spread));
                    item.y = jdh_pkg::SAMPLE_W'(near_sample(y_ctr, spread));
                end
                send_item(item);
                // Let the pipeline run completely dry once mid-phase.
                if (phase == 2 && n == 30)
                    wait_results_drained();
            end
        end
        steady = 1'b0;
    endtask

    task automatic report_mismatch(string what, logic want, logic got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("Mismatch on %s: expected %0b, got %0b", what, want, got);
    endtask

    // The result side: m_tready stalls at random, in stretches of varying
    // length, and stays high throughout whenever steady is set.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25)
                stall_left = pick_gap();
        end
    end

    // Each result transfer is compared, field by field, with the oldest
    // prediction still waiting.
    joy_result_t want_res;
    joy_result_t got_res;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = joy_result_t'(m_tdata);
            if (joy_results_due.size() == 0) begin
                report_mismatch("result with nothing expected", 1'b0, 1'b1);
            end else begin
                want_res = joy_results_due.pop_front();
                for (int i = 0; i < FIELD_COUNT; i++) begin
                    if (got_res[i] !== want_res[i])
                        report_mismatch(field_names[i], want_res[i], got_res[i]);
                end
            end
        end
    end

    initial begin
        // Every input of the block is at a known level from time zero.
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = jdh_pkg::REG_PRESS_OFFSET;
        cfg_data   = '0;
        stall_left = 0;
        steady     = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;

        // Predicted state as it stands after reset.
        press_ofs     = int'(jdh_pkg::PRESS_RESET);
        release_ofs   = int'(jdh_pkg::RELEASE_RESET);
        cal_cnt       = 0;
        x_acc         = 0;
        y_acc         = 0;
        x_ctr         = 0;
        y_ctr         = 0;
        is_calibrated = 1'b0;
        x_flags       = '0;
        y_flags       = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_calibration();
        test_directions();
        test_offset_extremes();
        test_random();

        // Drain, then give the two-stage pipeline time to show any stray
        // result before the verdict.
        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && joy_results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/jdh_pkg.sv
src/jdh_axis.sv
src/jdh_cal.sv
src/joystick_direction_hysteresis.sv
tb/sv/joystick_direction_hysteresis_tb.sv
